### hw/rtl/omi_pkg.sv
// shared types, codes and helpers for the offset to member and indices block
package omi_pkg;

   localparam int DEF_MAX_MEMBERS   = 64;
   localparam int DEF_MAX_DIMS      = 8;
   localparam int DEF_POINTER_BYTES = 8;

   // request type codes
   localparam logic [1:0] REQ_WR_ENTRY = 2'd0;
   localparam logic [1:0] REQ_WR_DIM   = 2'd1;
   localparam logic [1:0] REQ_LOOKUP   = 2'd2;

   // byte sizes saturate here
   localparam logic [32:0] SIZE_CAP = 33'h1_0000_0000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  entry_index;
      logic [2:0]  dim_index;
      logic        is_named;
      logic [31:0] member_offset;
      logic [31:0] elem_size;
      logic        is_reference;
      logic [5:0]  ref_width;
      logic        is_structured;
      logic [3:0]  num_dims;
      logic [15:0] dim_size;
      logic [31:0] query_offset;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [6:0]  member_index;
      logic [31:0] offset_in_member;
      logic        status;
      logic [3:0]  index_count;
      logic [2:0]  index_position;
      logic [15:0] index_value;
      logic        last;
   } rsp_item_type;

   // one stored member entry, named bit kept apart in flops
   typedef struct packed {
      logic [31:0] off;
      logic [31:0] elem;
      logic        is_ref;
      logic [5:0]  ref_width;
      logic        is_struct;
      logic [3:0]  nd;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic wr_entry;
      logic wr_dim;
      logic start;
      logic scan_inc;
      logic k_clr;
      logic k_inc;
      logic k_dec;
      logic k_load_last;
      logic k_load_nf;
      logic size_ref;
      logic size_elem;
      logic size_ptr;
      logic size_mul;
      logic hit;
      logic miss;
      logic nf_set;
      logic status_set;
      logic div_elem_start;
      logic div_dim_start;
      logic q_from_div;
      logic idx_wr;
      logic acc;
      logic grow;
      logic eo_commit;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_end;
      logic named;
      logic is_ref;
      logic is_struct;
      logic n_zero;
      logic k_eq_n;
      logic k_zero;
      logic dim_zero;
      logic match;
      logic elem_zero;
      logic nf_zero;
      logic div_done;
      logic out_free;
      logic p_last;
   } sts_type;

   function automatic logic [32:0] sat_mul(logic [32:0] a, logic [15:0] b);
      logic [48:0] p;
      p = 49'(a) * 49'(b);
      return (p > 49'(SIZE_CAP)) ? SIZE_CAP : p[32:0];
   endfunction

endpackage

### hw/rtl/omi_div.sv
// iterative restoring divider, one quotient bit per cycle
module omi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quot,
   output logic [31:0] rem
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] div_ff, div_in;
   logic [32:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quot_ff[31]};
      ge      = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? 32'(shifted - {1'b0, div_ff}) : shifted[31:0];
         quot_in = {quot_ff[30:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

### hw/rtl/omi_dp.sv
// datapath: member table, dimension memory, scan and index registers, result register
module omi_dp #(
   parameter int MAX_MEMBERS   = omi_pkg::DEF_MAX_MEMBERS,
   parameter int MAX_DIMS      = omi_pkg::DEF_MAX_DIMS,
   parameter int POINTER_BYTES = omi_pkg::DEF_POINTER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  omi_pkg::req_item_type req_item,
   input  omi_pkg::cmd_type      cmd,
   output omi_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output omi_pkg::rsp_item_type rsp_item
);

   localparam int ENT_W  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int SCAN_W = $clog2(MAX_MEMBERS + 1);
   localparam int KW     = $clog2(MAX_DIMS + 1);
   localparam int PW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DEPTH  = MAX_MEMBERS * MAX_DIMS;
   localparam int DA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   omi_pkg::entry_type    ent_mem [MAX_MEMBERS];
   logic [15:0]           dim_mem [DEPTH];
   logic [MAX_MEMBERS-1:0] named_ff;

   omi_pkg::entry_type    ent_rd_ff;
   omi_pkg::entry_type    new_ent;
   logic [15:0]           dim_rd_ff;

   logic [31:0]           q_ff;
   logic [SCAN_W-1:0]     scan_ff;
   logic [32:0]           size_ff;
   logic [KW-1:0]         k_ff;
   logic [KW-1:0]         nf_ff;
   logic                  found_ff;
   logic [31:0]           oim_ff;
   logic                  status_ff;
   logic                  idx_on_ff;
   logic [31:0]           quo_ff;
   logic [32:0]           l_ff;
   logic [31:0]           eo_ff;
   logic [15:0]           cur_idx_ff;
   logic [15:0]           idx_ff [MAX_DIMS];
   logic [PW-1:0]         p_ff;
   logic                  rsp_valid_ff;
   omi_pkg::rsp_item_type rsp_item_ff;

   logic [ENT_W-1:0]      wr_ent;
   logic [ENT_W-1:0]      rd_ent;
   logic                  ent_ok;
   logic                  dim_ok;
   logic [DA_W-1:0]       wr_addr;
   logic [DA_W-1:0]       rd_addr;
   logic [3:0]            nd_sat;
   logic                  div_start;
   logic [31:0]           div_dividend;
   logic [31:0]           div_divisor;
   logic                  div_done;
   logic [31:0]           div_quot;
   logic [31:0]           div_rem;
   logic [31:0]           q_diff;
   logic                  p_last;
   logic [48:0]           acc_prod;

   assign wr_ent  = ENT_W'(req_item.entry_index);
   assign rd_ent  = scan_ff[ENT_W-1:0];
   assign ent_ok  = 32'(req_item.entry_index) < 32'(MAX_MEMBERS);
   assign dim_ok  = ent_ok && (32'(req_item.dim_index) < 32'(MAX_DIMS));
   assign wr_addr = DA_W'(wr_ent) * DA_W'(MAX_DIMS) + DA_W'(req_item.dim_index);
   assign rd_addr = DA_W'(rd_ent) * DA_W'(MAX_DIMS) + DA_W'(k_ff);
   assign nd_sat  = (req_item.num_dims > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : req_item.num_dims;
   assign q_diff  = q_ff - ent_rd_ff.off;
   assign p_last  = idx_on_ff ? (KW'(p_ff) == KW'(nf_ff - KW'(1))) : 1'b1;
   assign acc_prod = 49'(cur_idx_ff) * 49'(l_ff);

   always_comb begin
      new_ent.off       = req_item.member_offset;
      new_ent.elem      = req_item.elem_size;
      new_ent.is_ref    = req_item.is_reference;
      new_ent.ref_width = req_item.ref_width;
      new_ent.is_struct = req_item.is_structured;
      new_ent.nd        = nd_sat;
   end

   // memories, registered read every cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_entry && ent_ok) begin
         ent_mem[wr_ent] <= new_ent;
      end
      if (cmd.wr_dim && dim_ok) begin
         dim_mem[wr_addr] <= req_item.dim_size;
      end
      ent_rd_ff <= ent_mem[rd_ent];
      dim_rd_ff <= dim_mem[rd_addr];
   end

   assign div_start    = cmd.div_elem_start | cmd.div_dim_start;
   assign div_dividend = cmd.div_dim_start ? quo_ff : oim_ff;
   assign div_divisor  = cmd.div_dim_start ? {16'd0, dim_rd_ff} : ent_rd_ff.elem;

   omi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         named_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_entry && ent_ok) begin
            named_ff[wr_ent] <= req_item.is_named;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.start) begin
         q_ff      <= req_item.query_offset;
         scan_ff   <= '0;
         status_ff <= 1'b0;
         idx_on_ff <= 1'b0;
         p_ff      <= '0;
      end
      if (cmd.scan_inc) scan_ff <= scan_ff + SCAN_W'(1);

      if (cmd.k_clr)       k_ff <= '0;
      if (cmd.k_inc)       k_ff <= k_ff + KW'(1);
      if (cmd.k_dec)       k_ff <= k_ff - KW'(1);
      if (cmd.k_load_last) k_ff <= KW'(ent_rd_ff.nd - 4'd1);
      if (cmd.k_load_nf)   k_ff <= nf_ff - KW'(1);
      if (cmd.nf_set)      nf_ff <= k_ff;

      if (cmd.size_ref)  size_ff <= 33'(ent_rd_ff.ref_width);
      if (cmd.size_elem) size_ff <= 33'(ent_rd_ff.elem);
      if (cmd.size_ptr)  size_ff <= 33'(POINTER_BYTES);
      if (cmd.size_mul)  size_ff <= omi_pkg::sat_mul(size_ff, dim_rd_ff);

      if (cmd.hit) begin
         found_ff <= 1'b1;
         oim_ff   <= q_diff;
      end
      if (cmd.miss) begin
         found_ff <= 1'b0;
         oim_ff   <= q_ff;
      end
      if (cmd.status_set) status_ff <= 1'b1;

      // mixed radix digits, last dimension first
      if (cmd.q_from_div) begin
         quo_ff <= div_quot;
         l_ff   <= 33'(ent_rd_ff.elem);
         eo_ff  <= '0;
      end
      if (cmd.idx_wr) begin
         idx_ff[k_ff[PW-1:0]] <= div_rem[15:0];
         cur_idx_ff           <= div_rem[15:0];
         quo_ff               <= div_quot;
      end
      if (cmd.acc)  eo_ff <= eo_ff + acc_prod[31:0];
      if (cmd.grow) l_ff  <= omi_pkg::sat_mul(l_ff, dim_rd_ff);
      if (cmd.eo_commit) begin
         idx_on_ff <= 1'b1;
         if (ent_rd_ff.is_struct) begin
            oim_ff <= (4'(nf_ff) == ent_rd_ff.nd) ? eo_ff : 32'd0;
         end
      end

      if (cmd.emit) begin
         rsp_item_ff.found            <= found_ff;
         rsp_item_ff.member_index     <= 7'(scan_ff);
         rsp_item_ff.offset_in_member <= oim_ff;
         rsp_item_ff.status           <= status_ff;
         rsp_item_ff.index_count      <= idx_on_ff ? 4'(nf_ff) : 4'd0;
         rsp_item_ff.index_position   <= idx_on_ff ? 3'(p_ff) : 3'd0;
         rsp_item_ff.index_value      <= idx_on_ff ? idx_ff[p_ff] : 16'd0;
         rsp_item_ff.last             <= p_last;
         p_ff                         <= p_ff + PW'(1);
      end
   end

   always_comb begin
      sts.scan_end  = scan_ff == SCAN_W'(MAX_MEMBERS);
      sts.named     = named_ff[rd_ent];
      sts.is_ref    = ent_rd_ff.is_ref;
      sts.is_struct = ent_rd_ff.is_struct;
      sts.n_zero    = ent_rd_ff.nd == 4'd0;
      sts.k_eq_n    = 4'(k_ff) == ent_rd_ff.nd;
      sts.k_zero    = k_ff == '0;
      sts.dim_zero  = dim_rd_ff == 16'd0;
      sts.match     = (q_ff >= ent_rd_ff.off) && ({1'b0, q_diff} < size_ff);
      sts.elem_zero = ent_rd_ff.elem == 32'd0;
      sts.nf_zero   = nf_ff == '0;
      sts.div_done  = div_done;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
      sts.p_last    = p_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### hw/rtl/omi_ctrl.sv
// controller: sequences writes, table scan, index digits and result delivery
module omi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_type,
   output logic             req_stall,
   input  omi_pkg::sts_type sts,
   output omi_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_ENT_RD,
      S_ENT_CHK,
      S_LD_WAIT,
      S_LD_CHK,
      S_PD_WAIT,
      S_PD_MUL,
      S_CMP,
      S_CF_WAIT,
      S_CF_CHK,
      S_CF_DONE,
      S_DIV_E,
      S_DIV_E_RUN,
      S_DJ_WAIT,
      S_DJ_START,
      S_DJ_RUN,
      S_DJ_ACC,
      S_DJ_GROW,
      S_FIN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  omi_pkg::REQ_WR_ENTRY: cmd.wr_entry = 1'b1;
                  omi_pkg::REQ_WR_DIM:   cmd.wr_dim = 1'b1;
                  omi_pkg::REQ_LOOKUP: begin
                     cmd.start = 1'b1;
                     state_in  = S_ENT_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_ENT_RD: begin
            if (sts.scan_end || !sts.named) begin
               cmd.miss = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_ENT_CHK;
            end
         end
         S_ENT_CHK: begin
            if (sts.is_ref) begin
               cmd.size_ref = 1'b1;
               state_in     = S_CMP;
            end else if (sts.n_zero) begin
               cmd.size_elem = 1'b1;
               state_in      = S_CMP;
            end else begin
               cmd.k_load_last = 1'b1;
               state_in        = S_LD_WAIT;
            end
         end
         S_LD_WAIT: state_in = S_LD_CHK;
         S_LD_CHK: begin
            if (sts.dim_zero) begin
               cmd.size_ptr = 1'b1;
               state_in     = S_CMP;
            end else begin
               cmd.size_elem = 1'b1;
               cmd.k_clr     = 1'b1;
               state_in      = S_PD_WAIT;
            end
         end
         S_PD_WAIT: state_in = sts.k_eq_n ? S_CMP : S_PD_MUL;
         S_PD_MUL: begin
            if (sts.dim_zero) begin
               state_in = S_CMP;
            end else begin
               cmd.size_mul = 1'b1;
               cmd.k_inc    = 1'b1;
               state_in     = S_PD_WAIT;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               cmd.hit = 1'b1;
               if (sts.n_zero || (sts.is_struct && sts.is_ref)) begin
                  state_in = S_EMIT;
               end else begin
                  cmd.k_clr = 1'b1;
                  state_in  = S_CF_WAIT;
               end
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_ENT_RD;
            end
         end
         S_CF_WAIT: begin
            if (sts.k_eq_n) begin
               cmd.nf_set = 1'b1;
               state_in   = S_CF_DONE;
            end else begin
               state_in = S_CF_CHK;
            end
         end
         S_CF_CHK: begin
            if (sts.dim_zero) begin
               cmd.nf_set = 1'b1;
               state_in   = S_CF_DONE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_CF_WAIT;
            end
         end
         S_CF_DONE: begin
            if (sts.nf_zero) begin
               state_in = S_EMIT;
            end else if (sts.elem_zero) begin
               cmd.status_set = 1'b1;
               state_in       = S_EMIT;
            end else begin
               state_in = S_DIV_E;
            end
         end
         S_DIV_E: begin
            cmd.div_elem_start = 1'b1;
            state_in           = S_DIV_E_RUN;
         end
         S_DIV_E_RUN: begin
            if (sts.div_done) begin
               cmd.q_from_div = 1'b1;
               cmd.k_load_nf  = 1'b1;
               state_in       = S_DJ_WAIT;
            end
         end
         S_DJ_WAIT: state_in = S_DJ_START;
         S_DJ_START: begin
            cmd.div_dim_start = 1'b1;
            state_in          = S_DJ_RUN;
         end
         S_DJ_RUN: begin
            if (sts.div_done) begin
               cmd.idx_wr = 1'b1;
               state_in   = S_DJ_ACC;
            end
         end
         S_DJ_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_DJ_GROW;
         end
         S_DJ_GROW: begin
            cmd.grow = 1'b1;
            if (sts.k_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.k_dec = 1'b1;
               state_in  = S_DJ_WAIT;
            end
         end
         S_FIN: begin
            cmd.eo_commit = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.p_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

### hw/rtl/offset_to_member_and_indices.sv
// top level: member layout table with byte offset lookup and array index split
//
//  channel  | direction | ports                          | moves
//  ---------+-----------+--------------------------------+-----------------------------
//  req      | in        | req_valid, req_stall, req_item | one write or lookup request
//  rsp      | out       | rsp_valid, rsp_stall, rsp_item | one result, up to MAX_DIMS
//
// a write request is done in S_IDLE and the next request may follow at once
// a lookup scans the table one entry at a time: S_ENT_RD, S_ENT_CHK and S_CMP for a
//   reference or scalar entry, with S_LD_WAIT, S_LD_CHK and an S_PD_WAIT, S_PD_MUL pass
//   per fixed dimension before S_CMP otherwise, all from the single dimension read port
// on a hit to a fixed array, the element divide and then one divide per fixed dimension
//   run in turn on the shared one-bit-a-cycle divider
// results leave one per cycle through the output register unless rsp stalls; the next
//   request is taken while the final result still waits there
// reset clears the named flags at once, no clearing pass; a stalled rsp holds
module offset_to_member_and_indices #(
   parameter int MAX_MEMBERS   = omi_pkg::DEF_MAX_MEMBERS,
   parameter int MAX_DIMS      = omi_pkg::DEF_MAX_DIMS,
   parameter int POINTER_BYTES = omi_pkg::DEF_POINTER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  omi_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output omi_pkg::rsp_item_type rsp_item
);

   omi_pkg::cmd_type cmd;
   omi_pkg::sts_type sts;

   // sequencer: scan, digit loop and result count
   omi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_item.req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table memories, size and digit arithmetic, result register
   omi_dp #(
      .MAX_MEMBERS   (MAX_MEMBERS),
      .MAX_DIMS      (MAX_DIMS),
      .POINTER_BYTES (POINTER_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   // a miss never carries indices
   a_miss_no_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.found |-> rsp_item.index_count == 4'd0 && !rsp_item.status)
      else $error("miss result carries indices or failure");

   // a zero element size failure is a single result without indices
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status |->
         rsp_item.found && rsp_item.last && rsp_item.index_count == 4'd0)
      else $error("failure result malformed");

   // index position stays inside the computed count
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.index_count != 4'd0 |->
         4'(rsp_item.index_position) < rsp_item.index_count)
      else $error("index position beyond count");

   // a new request is never taken between the results of one lookup
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !sts.p_last |=> req_stall)
      else $error("request taken between results");
`endif

endmodule

### test/tb_offset_to_member_and_indices.sv
// testbench for the offset to member and indices block: random table layouts and lookups
module tb_offset_to_member_and_indices;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = 64;
   localparam int NUM_DIMS    = 8;
   localparam int PTR_BYTES   = 8;
   localparam int ITEM_GOAL   = 170;
   localparam int CALM_TAIL   = 30;
   localparam int STUCK_LIMIT = 60000;
   localparam longint unsigned BYTE_CAP = 64'h1_0000_0000;
   // request type code that the block drops
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // expected lookup results, built from a private copy of the member table
   class layout_scoreboard;
      logic [31:0] offs [NUM_ENTRIES];
      logic [31:0] elems[NUM_ENTRIES];
      bit          named[NUM_ENTRIES];
      bit          refm [NUM_ENTRIES];
      bit          strm [NUM_ENTRIES];
      logic [5:0]  rwid [NUM_ENTRIES];
      int          ndim [NUM_ENTRIES];
      logic [15:0] dims [NUM_ENTRIES][NUM_DIMS];
      omi_pkg::rsp_item_type lookup_q[$];
      int          errors;

      function new();
         errors = 0;
         foreach (named[i]) begin
            named[i] = 0;
            ndim[i]  = 0;
         end
      endfunction

      function longint unsigned cap_mul(longint unsigned a, longint unsigned b);
         if (a == 0 || b == 0) return 0;
         if (a > BYTE_CAP) a = BYTE_CAP;
         if (b > BYTE_CAP) b = BYTE_CAP;
         if (a > BYTE_CAP / b) return BYTE_CAP;
         return (a * b > BYTE_CAP) ? BYTE_CAP : a * b;
      endfunction

      function longint unsigned span(int e);
         longint unsigned total;
         int n;
         n = ndim[e];
         if (refm[e]) return rwid[e];
         if (n == 0) return elems[e];
         if (dims[e][n-1] == 0) return PTR_BYTES;
         total = elems[e];
         for (int k = 0; k < n; k++) begin
            if (dims[e][k] == 0) break;
            total = cap_mul(total, dims[e][k]);
         end
         return total;
      endfunction

      function int fixed_dims(int e);
         int k;
         k = 0;
         while (k < ndim[e] && dims[e][k] != 0) k++;
         return k;
      endfunction

      function void note(omi_pkg::req_item_type r);
         longint unsigned q, oim, elem, size, lastsz, rem, eo, m;
         longint unsigned idx[NUM_DIMS];
         int i, n, cnt, nf;
         bit hit, status, fill;
         omi_pkg::rsp_item_type x;
         case (r.req_type)
            omi_pkg::REQ_WR_ENTRY: begin
               named[r.entry_index] = r.is_named;
               refm[r.entry_index]  = r.is_reference;
               strm[r.entry_index]  = r.is_structured;
               rwid[r.entry_index]  = r.ref_width;
               offs[r.entry_index]  = r.member_offset;
               elems[r.entry_index] = r.elem_size;
               // dimension count saturates on write
               ndim[r.entry_index]  = (r.num_dims > NUM_DIMS) ? NUM_DIMS : r.num_dims;
            end
            omi_pkg::REQ_WR_DIM: dims[r.entry_index][r.dim_index] = r.dim_size;
            omi_pkg::REQ_LOOKUP: begin
               foreach (idx[j]) idx[j] = 0;
               q = r.query_offset;
               status = 0;
               fill = 0;
               cnt = 0;
               for (i = 0; i < NUM_ENTRIES; i++) begin
                  if (!named[i]) break;
                  if (q >= offs[i] && q - offs[i] < span(i)) break;
               end
               hit = (i < NUM_ENTRIES) && named[i];
               oim = q;
               if (hit) begin
                  oim = q - offs[i];
                  n = ndim[i];
                  if (n != 0 && dims[i][0] != 0 && !(strm[i] && refm[i])) begin
                     elem = elems[i];
                     if (elem == 0) begin
                        status = 1;
                     end else begin
                        fill = 1;
                        size = elem;
                        lastsz = elem;
                        rem = oim;
                        nf = fixed_dims(i);
                        // mixed radix split, innermost dimension first
                        for (int j = nf - 1; j >= 0; j--) begin
                           size = cap_mul(size, dims[i][j]);
                           idx[j] = (rem % size) / lastsz;
                           rem -= lastsz * idx[j];
                           lastsz = size;
                        end
                        cnt = nf;
                        if (strm[i]) begin
                           eo = 0;
                           for (int j = 0; j < n; j++) begin
                              m = idx[j];
                              for (int k = j + 1; k < n; k++)
                                 if (m != 0) m = cap_mul(m, dims[i][k]);
                              eo += cap_mul(m, elem);
                           end
                           oim = eo;
                        end
                     end
                  end
               end
               if (cnt == 0) cnt = 1;
               for (int j = 0; j < cnt; j++) begin
                  x.found            = hit;
                  x.member_index     = 7'(i);
                  x.offset_in_member = oim[31:0];
                  x.status           = status;
                  x.index_count      = fill ? 4'(cnt) : 4'd0;
                  x.index_position   = fill ? 3'(j) : 3'd0;
                  x.index_value      = fill ? idx[j][15:0] : 16'd0;
                  x.last             = (j + 1 == cnt);
                  lookup_q.push_back(x);
               end
            end
            default: ;
         endcase
      endfunction

      function void check(omi_pkg::rsp_item_type got);
         omi_pkg::rsp_item_type want;
         if (lookup_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         want = lookup_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   omi_pkg::req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   omi_pkg::rsp_item_type rsp_item;

   layout_scoreboard sb;
   int  items_taken = 0;
   bit  calm = 0;               // no idling on either side when set
   int  stall_left = 0;
   int  stuck_cycles = 0;
   bit  dim_done[NUM_ENTRIES][NUM_DIMS];

   offset_to_member_and_indices i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // result side: check accepted results, stall in random bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check(rsp_item);
         if (stall_left > 0) stall_left--;
         else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
         rsp_stall <= (stall_left > 0);
      end
   end

   // watchdog: counts cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // a request with every don't-care field random, so all input bits toggle
   function automatic omi_pkg::req_item_type noise_fields(logic [1:0] kind);
      omi_pkg::req_item_type r;
      r.req_type      = kind;
      r.entry_index   = 6'($urandom);
      r.dim_index     = 3'($urandom);
      r.is_named      = 1'($urandom);
      r.member_offset = $urandom;
      r.elem_size     = $urandom;
      r.is_reference  = 1'($urandom);
      r.ref_width     = 6'($urandom);
      r.is_structured = 1'($urandom);
      r.num_dims      = 4'($urandom);
      r.dim_size      = 16'($urandom);
      r.query_offset  = $urandom;
      return r;
   endfunction

   // present one request, idle first at random, return once it is taken
   task automatic send(omi_pkg::req_item_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(r);
      items_taken++;
      if (ITEM_GOAL - items_taken < CALM_TAIL) calm = 1;
   endtask

   task automatic write_dim(int e, int d, logic [15:0] v);
      omi_pkg::req_item_type r;
      r = noise_fields(omi_pkg::REQ_WR_DIM);
      r.entry_index = 6'(e);
      r.dim_index   = 3'(d);
      r.dim_size    = v;
      send(r);
      dim_done[e][d] = 1;
   endtask

   // member write; any dimension it will read and that was never written is filled first
   task automatic write_entry(int e, bit nm, logic [31:0] off, logic [31:0] elem, bit rf,
                              logic [5:0] rw, bit st, logic [3:0] nd);
      omi_pkg::req_item_type r;
      int n;
      n = (nd > NUM_DIMS) ? NUM_DIMS : nd;
      for (int d = 0; d < n; d++)
         if (!dim_done[e][d]) write_dim(e, d, 16'($urandom_range(1, 4)));
      r = noise_fields(omi_pkg::REQ_WR_ENTRY);
      r.entry_index   = 6'(e);
      r.is_named      = nm;
      r.member_offset = off;
      r.elem_size     = elem;
      r.is_reference  = rf;
      r.ref_width     = rw;
      r.is_structured = st;
      r.num_dims      = nd;
      send(r);
   endtask

   task automatic lookup(logic [31:0] q);
      omi_pkg::req_item_type r;
      r = noise_fields(omi_pkg::REQ_LOOKUP);
      r.query_offset = q;
      send(r);
   endtask

   // write a table of count named members and, if room is left, an end marker, then probe it
   task automatic build_and_probe(int count, int probes, bit flat);
      longint unsigned cursor, sz;
      int kind, nd, e;
      logic [31:0] elem;
      cursor = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 64));
      for (e = 0; e < count; e++) begin
         kind = flat ? $urandom_range(0, 1) : $urandom_range(0, 5);
         nd = 0;
         elem = 32'($urandom_range(1, 12));
         case (kind)
            0: elem = 32'($urandom_range(0, 16));                  // scalar
            1: nd = $urandom_range(0, 2);                          // reference
            2: begin                                               // pointer
               nd = $urandom_range(1, 3);
               for (int d = 0; d < nd - 1; d++) write_dim(e, d, 16'($urandom_range(1, 4)));
               write_dim(e, nd - 1, 16'd0);
               if ($urandom_range(0, 2) == 0) elem = 0;
            end
            3, 4: begin                                            // fixed array
               nd = $urandom_range(1, 4);
               for (int d = 0; d < nd; d++)
                  write_dim(e, d, ($urandom_range(0, 7) == 0 && d > 0) ? 16'd0
                                                                    : 16'($urandom_range(1, 5)));
            end
            default: begin                                         // wide sizes
               nd = $urandom_range(0, 15);
               elem = $urandom;
               for (int d = 0; d < ((nd > NUM_DIMS) ? NUM_DIMS : nd); d++)
                  write_dim(e, d, 16'($urandom));
            end
         endcase
         if (kind == 1)
            for (int d = 0; d < nd; d++) write_dim(e, d, 16'($urandom_range(0, 4)));
         if (kind == 1 && $urandom_range(0, 1) == 0) elem = 0;
         write_entry(e, 1'b1, cursor[31:0], elem, kind == 1, 6'($urandom),
                     (kind == 4) || (kind != 3 && $urandom_range(0, 1) == 1), 4'(nd));
         sz = sb.span(e);
         cursor += ((sz > 4096) ? 4096 : sz)
                 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
      end
      if (count < NUM_ENTRIES) write_entry(count, 1'b0, $urandom, $urandom, 1'($urandom),
                                           6'($urandom), 1'($urandom), 4'($urandom_range(0, 8)));
      for (int p = 0; p < probes; p++) begin
         longint unsigned q;
         e = $urandom_range(0, count - 1);
         sz = sb.span(e);
         if ($urandom_range(0, 7) == 0) begin
            lookup($urandom);
         end else begin
            q = 64'(sb.offs[e]) + $urandom_range(0, ((sz > 300) ? 300 : sz) + 2);
            if ($urandom_range(0, 5) == 0) q = q - 1;
            lookup(q[31:0]);
         end
      end
   endtask

   initial begin
      omi_pkg::req_item_type r;
      sb = new();
      foreach (dim_done[i, j]) dim_done[i][j] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table: every lookup misses at entry zero
      lookup(32'd0);
      lookup(32'hFFFF_FFFF);
      // unknown request type is dropped
      r = noise_fields(REQ_UNKNOWN);
      send(r);

      // small hand-made layout
      write_entry(0, 1'b1, 32'd0, 32'd4, 1'b0, 6'd0, 1'b0, 4'd0);          // scalar
      write_dim(1, 0, 16'd2);
      write_dim(1, 1, 16'd3);
      write_entry(1, 1'b1, 32'd4, 32'd4, 1'b0, 6'd0, 1'b1, 4'd2);          // struct array
      write_entry(2, 1'b1, 32'd28, 32'd8, 1'b1, 6'd63, 1'b1, 4'd2);        // struct reference
      write_dim(3, 0, 16'd3);
      write_dim(3, 1, 16'd0);
      write_entry(3, 1'b1, 32'd92, 32'd0, 1'b0, 6'd0, 1'b0, 4'd2);         // pointer, zero elem
      for (int d = 0; d < NUM_DIMS; d++) write_dim(4, d, 16'hFFFF);
      write_entry(4, 1'b1, 32'd100, 32'hFFFF_FFFF, 1'b0, 6'd0, 1'b0, 4'd15); // saturating
      write_entry(5, 1'b0, 32'd0, 32'd0, 1'b0, 6'd0, 1'b0, 4'd0);          // end marker
      lookup(32'd3);
      lookup(32'd21);
      lookup(32'd28);
      lookup(32'd91);     // falls in a gap
      lookup(32'd95);
      lookup(32'hFFFF_FFFF);

      // one table filled to the end, then small random layouts with random content
      build_and_probe(NUM_ENTRIES, 6, 1'b1);
      while (items_taken < ITEM_GOAL) begin
         if ($urandom_range(0, 4) == 0) begin
            r = noise_fields(REQ_UNKNOWN);
            send(r);
         end
         build_and_probe($urandom_range(1, 4), $urandom_range(3, 8), 1'b0);
      end
      req_valid <= 1'b0;

      while (sb.lookup_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
